// ===== hdl/mi2x2_pkg.sv =====
`timescale 1ns / 1ps
// package for the 2x2 mutual information block
// payload structs, fixed-point constants; no dependencies

package mi2x2_pkg;

    // default weight width and fixed fraction widths
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int FRACTION_BITS   = 14;
    localparam int LOG_FRAC        = 24;
    localparam int CELL_W          = 16;

    // one input transfer: the four cells of the table
    typedef struct packed {
        logic [CELL_W-1:0] cell_00;
        logic [CELL_W-1:0] cell_01;
        logic [CELL_W-1:0] cell_10;
        logic [CELL_W-1:0] cell_11;
    } t_cells;

    // one result transfer
    typedef struct packed {
        logic [FRACTION_BITS:0]   row_entropy;
        logic [FRACTION_BITS:0]   column_entropy;
        logic [FRACTION_BITS+1:0] joint_entropy;
        logic [FRACTION_BITS:0]   mutual_info;
    } t_result;

endpackage

// ===== hdl/mutual_information_2x2.sv =====
`timescale 1ns / 1ps
// mutual_information_2x2: entropies and mutual information of a 2x2 table
// depends on mi2x2_pkg
//
// Takes one table per cycle and gives one result per cycle unless the output stalls.
// Stages: one input stage, three stages for sums and normalisation, 24 squaring
// stages for the nine log2 evaluations, two product and sum stages, a restoring
// divider that retires one quotient bit per stage, one stage of clamps and the
// output register. A stall on the output freezes the whole pipeline in place; the
// input is ready whenever the output register is empty or is being taken.

module mutual_information_2x2
    import mi2x2_pkg::*;
#(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_cells  i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    // widths
    localparam int SB  = WEIGHT_BITS + 2;        // sum of four weights
    localparam int NB  = $clog2(SB);             // log integer part
    localparam int QW  = NB + LOG_FRAC;          // log value and quotient
    localparam int PW  = SB + QW;                // weight times log
    localparam int AW  = PW + 2;                 // sum of four products
    localparam int LAT = QW + 32;
    localparam int HW  = LOG_FRAC + 2;           // clamped entropy
    localparam int SH  = LOG_FRAC - FRACTION_BITS;
    localparam logic [HW-1:0] ONE  = HW'(1) << LOG_FRAC;
    localparam logic [HW-1:0] TWO  = HW'(2) << LOG_FRAC;
    localparam logic [HW-1:0] HALF = HW'(1) << (SH - 1);

    // one squaring round: {fraction bit, new mantissa}
    function automatic logic [32:0] sq_step(input logic [31:0] m);
        logic [63:0] p;
        p = 64'(m) * 64'(m);
        if (p[63]) begin
            sq_step = {1'b1, p[63:32]};
        end else begin
            sq_step = {1'b0, p[62:31]};
        end
    endfunction

    logic           en;
    logic [LAT-1:0] r_vld;

    logic [WEIGHT_BITS-1:0] r_c [4];
    logic [SB-1:0]          r_x [9];
    logic [SB-1:0]          r_x2 [9];
    logic [NB-1:0]          r_n2 [9];

    logic [31:0]       r_m  [LOG_FRAC+1][9];
    logic [LOG_FRAC-1:0] r_f [LOG_FRAC+1][9];
    logic [SB-1:0]     r_lx [LOG_FRAC+1][9];
    logic [NB-1:0]     r_ln [LOG_FRAC+1][9];

    logic [SB+LOG_FRAC-1:0] r_pl [8];
    logic [SB+NB-1:0]       r_ph [8];
    logic [SB-1:0]          r_ps;
    logic [QW-1:0]          r_pls;

    logic [AW-1:0] r_rem [QW+1][3];
    logic [QW-1:0] r_q   [QW+1][3];
    logic [SB-1:0] r_ds  [QW+1];
    logic [QW-1:0] r_dls [QW+1];

    logic [HW-1:0] r_h [3];
    logic          r_z;
    t_result       r_out;

    // whole pipeline moves when the output register is free
    assign en          = ~r_vld[LAT-1] | i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // input, marginal sums, top-bit search and normalisation
    always_ff @(posedge i_clk) begin
        logic [NB-1:0]    n;
        logic [SB+30:0]   t;
        if (en) begin
            r_c[0] <= WEIGHT_BITS'(i_in_data.cell_00);
            r_c[1] <= WEIGHT_BITS'(i_in_data.cell_01);
            r_c[2] <= WEIGHT_BITS'(i_in_data.cell_10);
            r_c[3] <= WEIGHT_BITS'(i_in_data.cell_11);

            for (int i = 0; i < 4; i++) begin
                r_x[i] <= SB'(r_c[i]);
            end
            r_x[4] <= SB'(r_c[0]) + SB'(r_c[1]);
            r_x[5] <= SB'(r_c[2]) + SB'(r_c[3]);
            r_x[6] <= SB'(r_c[0]) + SB'(r_c[2]);
            r_x[7] <= SB'(r_c[1]) + SB'(r_c[3]);
            r_x[8] <= SB'(r_c[0]) + SB'(r_c[1]) + SB'(r_c[2]) + SB'(r_c[3]);

            for (int i = 0; i < 9; i++) begin
                n = '0;
                for (int b = 0; b < SB; b++) begin
                    if (r_x[i][b]) begin
                        n = NB'(b);
                    end
                end
                r_x2[i] <= r_x[i];
                r_n2[i] <= n;

                // x scaled to q1.31, low bits dropped
                t = {r_x2[i], 31'b0} >> r_n2[i];
                r_m[0][i]  <= t[31:0];
                r_f[0][i]  <= '0;
                r_lx[0][i] <= r_x2[i];
                r_ln[0][i] <= r_n2[i];
            end
        end
    end

    // squaring rounds, one fraction bit per stage
    always_ff @(posedge i_clk) begin
        logic [32:0] s;
        if (en) begin
            for (int k = 0; k < LOG_FRAC; k++) begin
                for (int i = 0; i < 9; i++) begin
                    s = sq_step(r_m[k][i]);
                    r_m[k+1][i]  <= s[31:0];
                    r_f[k+1][i]  <= {r_f[k][i][LOG_FRAC-2:0], s[32]};
                    r_lx[k+1][i] <= r_lx[k][i];
                    r_ln[k+1][i] <= r_ln[k][i];
                end
            end
        end
    end

    // weight times log, split into integer and fraction products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 8; i++) begin
                r_pl[i] <= (SB+LOG_FRAC)'(r_lx[LOG_FRAC][i]) *
                           (SB+LOG_FRAC)'(r_f[LOG_FRAC][i]);
                r_ph[i] <= (SB+NB)'(r_lx[LOG_FRAC][i]) * (SB+NB)'(r_ln[LOG_FRAC][i]);
            end
            r_ps  <= r_lx[LOG_FRAC][8];
            r_pls <= {r_ln[LOG_FRAC][8], r_f[LOG_FRAC][8]};
        end
    end

    // accumulate the products of each distribution
    always_ff @(posedge i_clk) begin
        logic [AW-1:0] p [8];
        if (en) begin
            for (int i = 0; i < 8; i++) begin
                p[i] = (AW'(r_ph[i]) << LOG_FRAC) + AW'(r_pl[i]);
            end
            r_rem[0][0] <= p[4] + p[5];
            r_rem[0][1] <= p[6] + p[7];
            r_rem[0][2] <= p[0] + p[1] + p[2] + p[3];
            for (int j = 0; j < 3; j++) begin
                r_q[0][j] <= '0;
            end
            r_ds[0]  <= r_ps;
            r_dls[0] <= r_pls;
        end
    end

    // restoring divider by the table sum, top quotient bit first
    always_ff @(posedge i_clk) begin
        logic [AW-1:0] d;
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                d = AW'(r_ds[k]) << (QW - 1 - k);
                for (int j = 0; j < 3; j++) begin
                    if (r_rem[k][j] >= d) begin
                        r_rem[k+1][j] <= r_rem[k][j] - d;
                        r_q[k+1][j]   <= r_q[k][j] | (QW'(1) << (QW - 1 - k));
                    end else begin
                        r_rem[k+1][j] <= r_rem[k][j];
                        r_q[k+1][j]   <= r_q[k][j];
                    end
                end
                r_ds[k+1]  <= r_ds[k];
                r_dls[k+1] <= r_dls[k];
            end
        end
    end

    // entropy from log of sum minus quotient, clamped
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] h;
        logic [HW-1:0] cap;
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                cap = (j == 2) ? TWO : ONE;
                h   = (r_q[QW][j] > r_dls[QW]) ? '0 : r_dls[QW] - r_q[QW][j];
                r_h[j] <= (QW'(cap) < h) ? cap : HW'(h);
            end
            r_z <= (r_ds[QW] == '0);
        end
    end

    // mutual information, rounding and zero-sum masking
    always_ff @(posedge i_clk) begin
        logic signed [HW:0] d;
        logic [HW-1:0]      mi;
        logic [HW-1:0]      hr;
        logic [HW-1:0]      hc;
        logic [HW-1:0]      hj;
        logic [HW-1:0]      hm;
        if (en) begin
            d  = $signed({1'b0, r_h[0]}) + $signed({1'b0, r_h[1]}) -
                 $signed({1'b0, r_h[2]});
            if (d < 0) begin
                mi = '0;
            end else if (d > $signed({1'b0, ONE})) begin
                mi = ONE;
            end else begin
                mi = HW'(d);
            end
            hr = (r_h[0] + HALF) >> SH;
            hc = (r_h[1] + HALF) >> SH;
            hj = (r_h[2] + HALF) >> SH;
            hm = (mi + HALF) >> SH;
            if (r_z) begin
                r_out <= '0;
            end else begin
                r_out.row_entropy    <= hr[FRACTION_BITS:0];
                r_out.column_entropy <= hc[FRACTION_BITS:0];
                r_out.joint_entropy  <= hj[FRACTION_BITS+1:0];
                r_out.mutual_info    <= hm[FRACTION_BITS:0];
            end
        end
    end

    // result bounds
    a_mi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.mutual_info <= (15'(1) << FRACTION_BITS))
        else $error("mutual information above one bit");

    a_marg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.row_entropy <= (15'(1) << FRACTION_BITS)) &&
                        (o_out_data.column_entropy <= (15'(1) << FRACTION_BITS)))
        else $error("marginal entropy above one bit");

    a_joint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.joint_entropy <= (16'(2) << FRACTION_BITS))
        else $error("joint entropy above two bits");

endmodule

// ===== bench/mi2x2_checker.sv =====
`timescale 1ns / 1ps
// checker for mutual_information_2x2: watches both channels, predicts entropies
// and compares each result transfer in order; depends on mi2x2_pkg

module mi2x2_checker
    import mi2x2_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_ready,
    input  t_cells  i_in_data,
    input  logic    i_out_valid,
    input  logic    i_out_ready,
    input  t_result i_out_data,
    output int      o_fail_count,
    output int      o_pending
);

    t_result expected_results[$];

    // log2 with 24 fraction bits by repeated squaring
    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        int unsigned top;
        logic [63:0] mant;
        logic [63:0] frac;
        top = 0;
        frac = 0;
        if (x == 0) return 0;
        while (top < 63 && (x >> (top + 1)) != 0) top++;
        if (top >= 31) mant = x >> (top - 31);
        else mant = x << (31 - top);
        for (int k = 0; k < LOG_FRAC; k++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd1 << 32)) begin
                mant = mant >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(top) << LOG_FRAC) | frac;
    endfunction

    // entropy of two or four weights against total
    function automatic logic [63:0] entropy_q24(input logic [63:0] w0, input logic [63:0] w1,
                                                input logic [63:0] w2, input logic [63:0] w3,
                                                input logic [63:0] total,
                                                input logic [63:0] cap);
        logic [63:0] acc;
        logic [63:0] quot;
        logic [63:0] lt;
        logic [63:0] h;
        acc = w0 * log2_q24(w0) + w1 * log2_q24(w1) + w2 * log2_q24(w2)
              + w3 * log2_q24(w3);
        quot = acc / total;
        lt = log2_q24(total);
        h = (quot > lt) ? 64'd0 : lt - quot;
        return (h > cap) ? cap : h;
    endfunction

    function automatic logic [63:0] round_q14(input logic [63:0] v);
        return (v + (64'd1 << (LOG_FRAC - FRACTION_BITS - 1))) >> (LOG_FRAC - FRACTION_BITS);
    endfunction

    function automatic t_result predict_entropies(input t_cells cells);
        logic [63:0] c0, c1, c2, c3, total, one, hr, hc, hj, mi;
        longint diff;
        t_result res;
        c0 = 64'(cells.cell_00);
        c1 = 64'(cells.cell_01);
        c2 = 64'(cells.cell_10);
        c3 = 64'(cells.cell_11);
        total = c0 + c1 + c2 + c3;
        one = 64'd1 << LOG_FRAC;
        res = '0;
        if (total == 0) return res;
        hr = entropy_q24(c0 + c1, c2 + c3, 64'd0, 64'd0, total, one);
        hc = entropy_q24(c0 + c2, c1 + c3, 64'd0, 64'd0, total, one);
        hj = entropy_q24(c0, c1, c2, c3, total, 64'd2 * one);
        diff = longint'(hr) + longint'(hc) - longint'(hj);
        if (diff < 0) mi = 0;
        else if (64'(diff) > one) mi = one;
        else mi = 64'(diff);
        res.row_entropy    = (FRACTION_BITS+1)'(round_q14(hr));
        res.column_entropy = (FRACTION_BITS+1)'(round_q14(hc));
        res.joint_entropy  = (FRACTION_BITS+2)'(round_q14(hj));
        res.mutual_info    = (FRACTION_BITS+1)'(round_q14(mi));
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // sample transfers on each edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_entropies(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.row_entropy != i_out_data.row_entropy ||
                        want.column_entropy != i_out_data.column_entropy ||
                        want.joint_entropy != i_out_data.joint_entropy ||
                        want.mutual_info != i_out_data.mutual_info) begin
                        $display("%0t: mismatch expected %h/%h/%h/%h actual %h/%h/%h/%h",
                                 $time, want.row_entropy, want.column_entropy,
                                 want.joint_entropy, want.mutual_info,
                                 i_out_data.row_entropy, i_out_data.column_entropy,
                                 i_out_data.joint_entropy, i_out_data.mutual_info);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// top of the mutual_information_2x2 bench: clock, reset, table stimulus and verdict
// depends on mi2x2_pkg, mi2x2_checker and the block itself

module testbench;
    import mi2x2_pkg::*;

    localparam int LATENCY     = 61;
    localparam int CYCLE_LIMIT = 400000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_cells  in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_result out_data;
    int      fail_count;
    int      pending;
    int      cycle_count = 0;
    int      send_idle_pct = 14;
    int      recv_idle_pct = 59;
    t_cells  tables[$];

    always #10 clk = ~clk;

    mutual_information_2x2 u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    mi2x2_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // timeout watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mutual_information_2x2 test failed");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [15:0] random_weight();
        case ($urandom_range(5))
            0: return 16'(0);
            1: return 16'hffff;
            2: return 16'($urandom_range(15));
            3: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    // directed tables: extremes, zero sum, single cells, independence
    task automatic load_directed();
        tables.push_back('{16'd0, 16'd0, 16'd0, 16'd0});
        tables.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff});
        tables.push_back('{16'hffff, 16'd0, 16'd0, 16'd0});
        tables.push_back('{16'd0, 16'hffff, 16'd0, 16'd0});
        tables.push_back('{16'd0, 16'd0, 16'hffff, 16'd0});
        tables.push_back('{16'd0, 16'd0, 16'd0, 16'd1});
        tables.push_back('{16'd1, 16'd0, 16'd0, 16'd1});
        tables.push_back('{16'd0, 16'hffff, 16'hffff, 16'd0});
        tables.push_back('{16'd1, 16'd1, 16'd1, 16'd1});
        tables.push_back('{16'd1, 16'd1, 16'd0, 16'd0});
        tables.push_back('{16'd1, 16'd0, 16'd1, 16'd0});
        tables.push_back('{16'd1, 16'd2, 16'd3, 16'd6});
        tables.push_back('{16'hffff, 16'd1, 16'd1, 16'd0});
        tables.push_back('{16'haaaa, 16'h5555, 16'h5555, 16'haaaa});
        tables.push_back('{16'h5555, 16'haaaa, 16'haaaa, 16'h5555});
        tables.push_back('{16'h8000, 16'h7fff, 16'h0001, 16'hfffe});
    endtask

    // present one table and hold it until accepted
    task automatic send_table(input t_cells cells);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cells;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial begin
        int settle;
        t_cells cells;
        load_directed();
        for (int n = 0; n < 2000; n++) begin
            cells = '{random_weight(), random_weight(), random_weight(), random_weight()};
            tables.push_back(cells);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int n = 0; n < tables.size(); n++) begin
            if (n == 700) begin
                send_idle_pct = 59;
                recv_idle_pct = 14;
            end else if (n == 1400) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_table(tables[n]);
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        settle = 0;
        while (settle < 2 * LATENCY) begin
            @(posedge clk);
            settle++;
        end
        if (fail_count == 0) begin
            $display("mutual_information_2x2 test passed");
        end else begin
            $display("mutual_information_2x2 test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mi2x2_pkg.sv
hdl/mutual_information_2x2.sv
bench/mi2x2_checker.sv
bench/testbench.sv
